// ----- rtl/aarm_pkg.sv -----
// shared types, fixed-point constants and stage counts for the rotation matrix unit
// no dependencies

package aarm_pkg;

    localparam logic [30:0] ONE_Q30 = 31'd1073741824;
    localparam logic [34:0] HALF_PI_Q30 = 35'd1686629713;
    localparam logic [34:0] HALF_PI_HALF = 35'd843314856;
    // eight quarter turns plus half a quarter turn
    localparam logic signed [35:0] ANGLE_OFFSET = 36'sd14336352560;

    localparam int unsigned SIN_DIV [4] = '{72, 42, 20, 6};
    localparam int unsigned COS_DIV [5] = '{90, 56, 30, 12, 2};

    localparam int unsigned ROOT_BITS = 32;
    localparam int unsigned QUO_BITS = 32;
    localparam int unsigned AXIS_PRE = 6;
    localparam int unsigned AXIS_LAT = AXIS_PRE + ROOT_BITS + 1 + QUO_BITS + 1;
    localparam int unsigned POLY_LAT = 4;
    localparam int unsigned TRIG_LAT = 5 + 5 * POLY_LAT + 1;
    localparam int unsigned TRIG_PAD = AXIS_LAT - TRIG_LAT;
    localparam int unsigned MAT_LAT = 5;
    localparam int unsigned TOTAL_LAT = AXIS_LAT + MAT_LAT;

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_1,
        QUAD_2,
        QUAD_3
    } aarm_quad_t;

    typedef struct packed {
        logic signed [31:0] sn;
        logic signed [31:0] cs;
    } aarm_trig_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic degen;
    } aarm_unit_t;

endpackage

// ----- rtl/axis_angle_rotation_matrix_unit.sv -----
// top level: axis-angle to 3x3 rotation matrix, streaming in and out
// depends on aarm_pkg, aarm_axis_norm, aarm_sincos, aarm_matrix
//
// channel   dir  fields (low bit first)
// s_axis    in   tdata: angle, axis_x, axis_y, axis_z
// m_axis    out  tdata: entry_00..entry_22; tuser: axis_degenerate
//
// one transfer in per cycle while the output is not stalled, 77 register
// stages; the result sits in the output register; most stages are the
// 32-stage square root and 32-stage divider of the axis path
// reset clears only the valid bits; payload registers are not reset
// a stalled output holds every stage, nothing dropped or repeated

module axis_angle_rotation_matrix_unit
    import aarm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // angle, axis_x, axis_y, axis_z
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [287:0] m_axis_tdata,  // entry_00 .. entry_22
    output logic         m_axis_tuser   // axis_degenerate
);

    logic adv;
    logic [TOTAL_LAT-1:0] valid_reg, valid_next;
    aarm_trig_t trig_early;
    aarm_trig_t trig_pipe_reg [TRIG_PAD];
    aarm_unit_t unit;
    logic [8:0][31:0] entry;

    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;
    assign valid_next = {valid_reg[TOTAL_LAT-2:0], s_axis_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
        end
    end

    aarm_axis_norm u_axis_norm (
        .clk    (clk),
        .en     (adv),
        .axis_x (s_axis_tdata[63:32]),
        .axis_y (s_axis_tdata[95:64]),
        .axis_z (s_axis_tdata[127:96]),
        .unit   (unit)
    );

    aarm_sincos u_sincos (
        .clk   (clk),
        .en    (adv),
        .angle (s_axis_tdata[31:0]),
        .trig  (trig_early)
    );

    // line up sine and cosine with the unit axis
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            trig_pipe_reg[0] <= trig_early;
            for (int i = 1; i < TRIG_PAD; i++)
            begin
                trig_pipe_reg[i] <= trig_pipe_reg[i - 1];
            end
        end
    end

    aarm_matrix u_matrix (
        .clk   (clk),
        .en    (adv),
        .unit  (unit),
        .trig  (trig_pipe_reg[TRIG_PAD - 1]),
        .entry (entry),
        .degen (m_axis_tuser)
    );

    assign m_axis_tdata = entry;
    assign m_axis_tvalid = valid_reg[TOTAL_LAT-1];

endmodule

// ----- rtl/aarm_poly_step.sv -----
// one horner step of the sine and cosine series: t_out = 1 - round(x2*t)/DIV
// depends on aarm_pkg

module aarm_poly_step
    import aarm_pkg::*;
#(
    parameter int unsigned DIV = 2
)
(
    input  logic        clk,
    input  logic        en,
    input  logic [29:0] x2_in,
    input  logic [30:0] t_in,
    output logic [29:0] x2_out,
    output logic [30:0] t_out
);

    localparam logic [35:0] RECIP = 36'((64'd1 << 36) / DIV);
    localparam logic [37:0] DIV_W = 38'(DIV);

    logic [60:0] prod_reg, prod_next;
    logic [30:0] m2_reg, m2_next, m3_reg;
    logic [66:0] qp_reg, qp_next;
    logic [30:0] t_reg, t_next;
    logic [29:0] x2_reg [POLY_LAT];

    logic [30:0] q0;
    logic [37:0] qd;
    logic [37:0] rm;
    logic [30:0] q;

    always_comb
    begin
        prod_next = 61'(x2_in) * 61'(t_in);
        m2_next = 31'((prod_reg + 61'd536870912) >> 30);
        qp_next = 67'(m2_reg) * 67'(RECIP);
        q0 = qp_reg[66:36];
        qd = 38'(q0) * DIV_W;
        rm = 38'(m3_reg) - qd;
        q = (rm >= DIV_W) ? q0 + 31'd1 : q0;
        t_next = ONE_Q30 - q;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            m2_reg <= m2_next;
            m3_reg <= m2_reg;
            qp_reg <= qp_next;
            t_reg <= t_next;
            x2_reg[0] <= x2_in;
            for (int i = 1; i < POLY_LAT; i++)
            begin
                x2_reg[i] <= x2_reg[i - 1];
            end
        end
    end

    assign x2_out = x2_reg[POLY_LAT - 1];
    assign t_out = t_reg;

endmodule

// ----- rtl/aarm_sincos.sv -----
// angle reduction by quarter turns, series sine and cosine, quadrant fix-up
// depends on aarm_pkg and aarm_poly_step

module aarm_sincos
    import aarm_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] angle,
    output aarm_trig_t         trig
);

    localparam int unsigned R_DLY = 4 * POLY_LAT + 2;
    localparam int unsigned Q_DLY = 5 * POLY_LAT + 2;

    logic [34:0] u1_reg, u1_next, u2_reg;
    logic [3:0] k2_reg, k2_next;
    logic signed [31:0] r3_reg, r3_next;
    aarm_quad_t quad3_reg;
    logic signed [63:0] prod4_reg, prod4_next;
    logic [29:0] x2_reg, x2_next;
    logic signed [31:0] r_pipe_reg [R_DLY];
    aarm_quad_t quad_pipe_reg [Q_DLY];
    logic signed [63:0] sp_reg, sp_next;
    logic signed [31:0] sv_reg, sv_next, sv_d1_reg, sv_d2_reg;
    aarm_trig_t trig_reg, trig_next;

    logic signed [35:0] u_wide;
    logic [34:0] r_full;
    logic signed [31:0] cv;

    logic [29:0] sin_x2 [5];
    logic [30:0] sin_t [5];
    logic [29:0] cos_x2 [6];
    logic [30:0] cos_t [6];

    assign sin_x2[0] = x2_reg;
    assign sin_t[0] = ONE_Q30;
    assign cos_x2[0] = x2_reg;
    assign cos_t[0] = ONE_Q30;

    for (genvar g = 0; g < 4; g++)
    begin : g_sin
        aarm_poly_step #(.DIV(SIN_DIV[g])) u_step (
            .clk    (clk),
            .en     (en),
            .x2_in  (sin_x2[g]),
            .t_in   (sin_t[g]),
            .x2_out (sin_x2[g + 1]),
            .t_out  (sin_t[g + 1])
        );
    end

    for (genvar g = 0; g < 5; g++)
    begin : g_cos
        aarm_poly_step #(.DIV(COS_DIV[g])) u_step (
            .clk    (clk),
            .en     (en),
            .x2_in  (cos_x2[g]),
            .t_in   (cos_t[g]),
            .x2_out (cos_x2[g + 1]),
            .t_out  (cos_t[g + 1])
        );
    end

    always_comb
    begin
        u_wide = {{2{angle[31]}}, angle, 2'b00} + ANGLE_OFFSET;
        u1_next = u_wide[34:0];
        k2_next = '0;
        for (int j = 1; j < 15; j++)
        begin
            if (u1_reg >= 35'(j) * HALF_PI_Q30)
            begin
                k2_next = k2_next + 4'd1;
            end
        end
        r_full = u2_reg - HALF_PI_HALF - 35'(k2_reg) * HALF_PI_Q30;
        r3_next = r_full[31:0];
        prod4_next = r3_reg * r3_reg;
        x2_next = 30'((prod4_reg + 64'sd536870912) >>> 30);
        sp_next = r_pipe_reg[R_DLY - 1] * $signed({1'b0, sin_t[4]});
        sv_next = 32'((sp_reg + 64'sd536870912) >>> 30);
        cv = $signed({1'b0, cos_t[5]});
        case (quad_pipe_reg[Q_DLY - 1])
            QUAD_0:
            begin
                trig_next.sn = sv_d2_reg;
                trig_next.cs = cv;
            end
            QUAD_1:
            begin
                trig_next.sn = cv;
                trig_next.cs = -sv_d2_reg;
            end
            QUAD_2:
            begin
                trig_next.sn = -sv_d2_reg;
                trig_next.cs = -cv;
            end
            default:
            begin
                trig_next.sn = -cv;
                trig_next.cs = sv_d2_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u1_reg <= u1_next;
            u2_reg <= u1_reg;
            k2_reg <= k2_next;
            r3_reg <= r3_next;
            quad3_reg <= aarm_quad_t'(k2_reg[1:0]);
            prod4_reg <= prod4_next;
            x2_reg <= x2_next;
            r_pipe_reg[0] <= r3_reg;
            for (int i = 1; i < R_DLY; i++)
            begin
                r_pipe_reg[i] <= r_pipe_reg[i - 1];
            end
            quad_pipe_reg[0] <= quad3_reg;
            for (int i = 1; i < Q_DLY; i++)
            begin
                quad_pipe_reg[i] <= quad_pipe_reg[i - 1];
            end
            sp_reg <= sp_next;
            sv_reg <= sv_next;
            sv_d1_reg <= sv_reg;
            sv_d2_reg <= sv_d1_reg;
            trig_reg <= trig_next;
        end
    end

    assign trig = trig_reg;

endmodule

// ----- rtl/aarm_axis_norm.sv -----
// axis normalization: power-of-two scaling, pipelined square root, pipelined division
// depends on aarm_pkg

module aarm_axis_norm
    import aarm_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] axis_x,
    input  logic signed [31:0] axis_y,
    input  logic signed [31:0] axis_z,
    output aarm_unit_t         unit
);

    typedef struct packed {
        logic [2:0][29:0] mag;
        logic [2:0] neg;
        logic degen;
    } side_t;

    typedef struct packed {
        logic [2:0] neg;
        logic degen;
    } flag_t;

    logic signed [31:0] comp [3];
    logic [2:0][31:0] mag1_reg, mag1_next, mag2_reg, mag3_reg;
    logic [2:0] neg1_reg, neg2_reg, neg3_reg;
    logic [31:0] max2_reg, max2_next;
    logic [4:0] msb;
    logic [4:0] left3_reg, left3_next;
    logic [1:0] right3_reg, right3_next;
    logic degen3_reg;
    side_t side4_reg, side4_next, side5_reg;
    logic [2:0][59:0] sq5_reg, sq5_next;
    logic [61:0] sum5;

    logic [65:0] rem_reg [ROOT_BITS + 1];
    logic [31:0] root_reg [ROOT_BITS + 1];
    side_t side_reg [ROOT_BITS + 1];

    logic [61:0] drem_reg [QUO_BITS + 1][3];
    logic [31:0] quo_reg [QUO_BITS + 1][3];
    logic [31:0] l2_reg [QUO_BITS + 1];
    flag_t flag_reg [QUO_BITS + 1];

    aarm_unit_t unit_reg, unit_next;

    assign comp[0] = axis_x;
    assign comp[1] = axis_y;
    assign comp[2] = axis_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag1_next[i] = comp[i][31] ? 32'(-comp[i]) : 32'(comp[i]);
        end
        max2_next = mag1_reg[0];
        if (mag1_reg[1] > max2_next)
        begin
            max2_next = mag1_reg[1];
        end
        if (mag1_reg[2] > max2_next)
        begin
            max2_next = mag1_reg[2];
        end
        msb = '0;
        for (int b = 0; b < 32; b++)
        begin
            if (max2_reg[b])
            begin
                msb = 5'(b);
            end
        end
        left3_next = (msb < 5'd29) ? 5'd29 - msb : 5'd0;
        right3_next = (msb > 5'd29) ? 2'(msb - 5'd29) : 2'd0;
        for (int i = 0; i < 3; i++)
        begin
            side4_next.mag[i] = 30'((mag3_reg[i] >> right3_reg) << left3_reg);
        end
        side4_next.neg = neg3_reg;
        side4_next.degen = degen3_reg;
        for (int i = 0; i < 3; i++)
        begin
            sq5_next[i] = 60'(side4_reg.mag[i]) * 60'(side4_reg.mag[i]);
        end
        sum5 = 62'(sq5_reg[0]) + 62'(sq5_reg[1]) + 62'(sq5_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag1_reg <= mag1_next;
            neg1_reg <= {axis_z[31], axis_y[31], axis_x[31]};
            mag2_reg <= mag1_reg;
            neg2_reg <= neg1_reg;
            max2_reg <= max2_next;
            mag3_reg <= mag2_reg;
            neg3_reg <= neg2_reg;
            left3_reg <= left3_next;
            right3_reg <= right3_next;
            degen3_reg <= (max2_reg == 32'd0);
            side4_reg <= side4_next;
            side5_reg <= side4_reg;
            sq5_reg <= sq5_next;
            rem_reg[0] <= {2'b00, sum5, 2'b00};
            root_reg[0] <= '0;
            side_reg[0] <= side5_reg;
        end
    end

    // square root, one result bit per stage
    for (genvar s = 0; s < ROOT_BITS; s++)
    begin : g_root
        localparam int unsigned BIT = ROOT_BITS - 1 - s;
        logic [65:0] trial;
        logic [65:0] rem_next;
        logic [31:0] root_next;

        always_comb
        begin
            trial = (66'(root_reg[s]) << (BIT + 1)) + (66'd1 << (2 * BIT));
            if (rem_reg[s] >= trial)
            begin
                rem_next = rem_reg[s] - trial;
                root_next = root_reg[s] | (32'd1 << BIT);
            end
            else
            begin
                rem_next = rem_reg[s];
                root_next = root_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s + 1] <= rem_next;
                root_reg[s + 1] <= root_next;
                side_reg[s + 1] <= side_reg[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 3; l++)
            begin
                drem_reg[0][l] <= {side_reg[ROOT_BITS].mag[l], 31'd0}
                    + 62'(root_reg[ROOT_BITS] >> 1);
                quo_reg[0][l] <= '0;
            end
            l2_reg[0] <= root_reg[ROOT_BITS];
            flag_reg[0].neg <= side_reg[ROOT_BITS].neg;
            flag_reg[0].degen <= side_reg[ROOT_BITS].degen;
        end
    end

    // restoring division, one quotient bit per stage in each lane
    for (genvar s = 0; s < QUO_BITS; s++)
    begin : g_div
        localparam int unsigned BIT = QUO_BITS - 1 - s;
        logic [63:0] dsh;
        logic [61:0] drem_next [3];
        logic [31:0] quo_next [3];

        always_comb
        begin
            dsh = 64'(l2_reg[s]) << BIT;
            for (int l = 0; l < 3; l++)
            begin
                if ({2'b00, drem_reg[s][l]} >= dsh)
                begin
                    drem_next[l] = drem_reg[s][l] - dsh[61:0];
                    quo_next[l] = quo_reg[s][l] | (32'd1 << BIT);
                end
                else
                begin
                    drem_next[l] = drem_reg[s][l];
                    quo_next[l] = quo_reg[s][l];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int l = 0; l < 3; l++)
                begin
                    drem_reg[s + 1][l] <= drem_next[l];
                    quo_reg[s + 1][l] <= quo_next[l];
                end
                l2_reg[s + 1] <= l2_reg[s];
                flag_reg[s + 1] <= flag_reg[s];
            end
        end
    end

    always_comb
    begin
        unit_next.x = flag_reg[QUO_BITS].neg[0] ? -$signed(quo_reg[QUO_BITS][0])
            : $signed(quo_reg[QUO_BITS][0]);
        unit_next.y = flag_reg[QUO_BITS].neg[1] ? -$signed(quo_reg[QUO_BITS][1])
            : $signed(quo_reg[QUO_BITS][1]);
        unit_next.z = flag_reg[QUO_BITS].neg[2] ? -$signed(quo_reg[QUO_BITS][2])
            : $signed(quo_reg[QUO_BITS][2]);
        unit_next.degen = flag_reg[QUO_BITS].degen;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            unit_reg <= unit_next;
        end
    end

    assign unit = unit_reg;

endmodule

// ----- rtl/aarm_matrix.sv -----
// rodrigues matrix entries from unit axis, sine and cosine, with saturation
// depends on aarm_pkg

module aarm_matrix
    import aarm_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  aarm_unit_t       unit,
    input  aarm_trig_t       trig,
    output logic [8:0][31:0] entry,
    output logic             degen
);

    // product order: xx yy zz xy xz yz, then xs ys zs
    logic signed [63:0] p1_reg [9];
    logic signed [63:0] p1_next [9];
    logic signed [32:0] omc1_reg, omc2_reg;
    logic signed [31:0] cs1_reg, cs2_reg, cs3_reg, cs4_reg;
    logic [4:1] degen_reg;
    logic signed [31:0] r2_reg [9];
    logic signed [64:0] q3_reg [6];
    logic signed [31:0] s3_reg [3], s4_reg [3];
    logic signed [32:0] w4_reg [6];
    logic [8:0][31:0] entry_reg, entry_next;
    logic degen5_reg;

    logic signed [31:0] u [3];
    logic signed [34:0] e [9];

    function automatic logic [31:0] sat32(input logic signed [34:0] v);
        logic [31:0] res;
        if (v > 35'sd2147483647)
        begin
            res = 32'h7fffffff;
        end
        else if (v < -35'sd2147483648)
        begin
            res = 32'h80000000;
        end
        else
        begin
            res = v[31:0];
        end
        return res;
    endfunction

    assign u[0] = unit.x;
    assign u[1] = unit.y;
    assign u[2] = unit.z;

    always_comb
    begin
        p1_next[0] = u[0] * u[0];
        p1_next[1] = u[1] * u[1];
        p1_next[2] = u[2] * u[2];
        p1_next[3] = u[0] * u[1];
        p1_next[4] = u[0] * u[2];
        p1_next[5] = u[1] * u[2];
        for (int i = 0; i < 3; i++)
        begin
            p1_next[6 + i] = u[i] * trig.sn;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 9; i++)
            begin
                p1_reg[i] <= p1_next[i];
                r2_reg[i] <= 32'((p1_reg[i] + 64'sd536870912) >>> 30);
            end
            omc1_reg <= $signed({2'b00, ONE_Q30}) - 33'(trig.cs);
            cs1_reg <= trig.cs;
            degen_reg[1] <= unit.degen;
            omc2_reg <= omc1_reg;
            cs2_reg <= cs1_reg;
            degen_reg[2] <= degen_reg[1];
            for (int i = 0; i < 6; i++)
            begin
                q3_reg[i] <= r2_reg[i] * omc2_reg;
                w4_reg[i] <= 33'((q3_reg[i] + 65'sd536870912) >>> 30);
            end
            for (int i = 0; i < 3; i++)
            begin
                s3_reg[i] <= r2_reg[6 + i];
                s4_reg[i] <= s3_reg[i];
            end
            cs3_reg <= cs2_reg;
            cs4_reg <= cs3_reg;
            degen_reg[3] <= degen_reg[2];
            degen_reg[4] <= degen_reg[3];
            entry_reg <= entry_next;
            degen5_reg <= degen_reg[4];
        end
    end

    always_comb
    begin
        e[0] = 35'(cs4_reg) + 35'(w4_reg[0]);
        e[1] = 35'(w4_reg[3]) + 35'(s4_reg[2]);
        e[2] = 35'(w4_reg[4]) - 35'(s4_reg[1]);
        e[3] = 35'(w4_reg[3]) - 35'(s4_reg[2]);
        e[4] = 35'(cs4_reg) + 35'(w4_reg[1]);
        e[5] = 35'(w4_reg[5]) + 35'(s4_reg[0]);
        e[6] = 35'(w4_reg[4]) + 35'(s4_reg[1]);
        e[7] = 35'(w4_reg[5]) - 35'(s4_reg[0]);
        e[8] = 35'(cs4_reg) + 35'(w4_reg[2]);
        for (int i = 0; i < 9; i++)
        begin
            if (degen_reg[4])
            begin
                // zero axis gives the identity
                entry_next[i] = (i % 4 == 0) ? 32'(ONE_Q30) : 32'd0;
            end
            else
            begin
                entry_next[i] = sat32(e[i]);
            end
        end
    end

    assign entry = entry_reg;
    assign degen = degen5_reg;

endmodule

// ----- tb/tb_rotation_checker.sv -----
`timescale 1ns / 100ps
// checker for the rotation matrix unit: watches both stream channels,
// computes the expected matrix per input transfer and compares; depends on aarm_pkg

module tb_rotation_checker
    import aarm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [287:0] m_axis_tdata,
    input  logic         m_axis_tuser,
    output int           fail_count,
    output int           pending
);

    typedef struct {
        logic [287:0] entries;
        logic         degen;
    } matrix_t;

    matrix_t expected_mats[$];

    function automatic longint rnd_q30(longint a, longint b);
        longint p;
        p = a * b + (64'sd1 <<< 29);
        return p >>> 30;
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [63:0] root64(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic matrix_t rotation_of(logic [127:0] d);
        matrix_t mt;
        longint comp[3];
        longint mag[3];
        longint unitv[3];
        longint e[9];
        logic [63:0] mx, sum, l2, num;
        longint hp, a, u, k, r, x2, t, sv, cv, sn, cs, omc, xy, xz, yz;
        hp = 64'sd1686629713;
        mx = 0;
        for (int i = 0; i < 3; i++)
        begin
            comp[i] = longint'($signed(d[32*(i+1) +: 32]));
            mag[i] = comp[i] < 0 ? -comp[i] : comp[i];
            if (mag[i] > mx)
                mx = mag[i];
        end
        if (mx == 0)
        begin
            mt.entries = '0;
            for (int i = 0; i < 9; i += 4)
                mt.entries[32*i +: 32] = 32'h4000_0000;
            mt.degen = 1'b1;
            return mt;
        end
        while (mx < (64'd1 << 29))
        begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++)
                mag[i] = mag[i] << 1;
        end
        while (mx >= (64'd1 << 30))
        begin
            mx = mx >> 1;
            for (int i = 0; i < 3; i++)
                mag[i] = mag[i] >> 1;
        end
        sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
        l2 = root64(sum << 2);
        for (int i = 0; i < 3; i++)
        begin
            num = ((64'(mag[i]) << 31) + (l2 >> 1)) / l2;
            unitv[i] = comp[i] < 0 ? -longint'(num) : longint'(num);
        end
        a = longint'($signed(d[31:0])) * 4;
        u = a + 8 * hp + hp / 2;
        k = u / hp;
        r = u - k * hp - hp / 2;
        x2 = rnd_q30(r, r);
        t = (64'sd1 <<< 30) - x2 / 72;
        t = (64'sd1 <<< 30) - rnd_q30(x2, t) / 42;
        t = (64'sd1 <<< 30) - rnd_q30(x2, t) / 20;
        t = (64'sd1 <<< 30) - rnd_q30(x2, t) / 6;
        sv = rnd_q30(r, t);
        t = (64'sd1 <<< 30) - x2 / 90;
        t = (64'sd1 <<< 30) - rnd_q30(x2, t) / 56;
        t = (64'sd1 <<< 30) - rnd_q30(x2, t) / 30;
        t = (64'sd1 <<< 30) - rnd_q30(x2, t) / 12;
        cv = (64'sd1 <<< 30) - rnd_q30(x2, t) / 2;
        case (aarm_quad_t'(k[1:0]))
            QUAD_0:  begin sn = sv;  cs = cv;  end
            QUAD_1:  begin sn = cv;  cs = -sv; end
            QUAD_2:  begin sn = -sv; cs = -cv; end
            default: begin sn = -cv; cs = sv;  end
        endcase
        omc = (64'sd1 <<< 30) - cs;
        xy = rnd_q30(rnd_q30(unitv[0], unitv[1]), omc);
        xz = rnd_q30(rnd_q30(unitv[0], unitv[2]), omc);
        yz = rnd_q30(rnd_q30(unitv[1], unitv[2]), omc);
        e[0] = cs + rnd_q30(rnd_q30(unitv[0], unitv[0]), omc);
        e[1] = xy + rnd_q30(unitv[2], sn);
        e[2] = xz - rnd_q30(unitv[1], sn);
        e[3] = xy - rnd_q30(unitv[2], sn);
        e[4] = cs + rnd_q30(rnd_q30(unitv[1], unitv[1]), omc);
        e[5] = yz + rnd_q30(unitv[0], sn);
        e[6] = xz + rnd_q30(unitv[1], sn);
        e[7] = yz - rnd_q30(unitv[0], sn);
        e[8] = cs + rnd_q30(rnd_q30(unitv[2], unitv[2]), omc);
        for (int i = 0; i < 9; i++)
            mt.entries[32*i +: 32] = 32'(sat32(e[i]));
        mt.degen = 1'b0;
        return mt;
    endfunction

    assign pending = expected_mats.size();

    always @(posedge clk or negedge rst_n)
    begin
        matrix_t want;
        int errs;
        if (!rst_n)
        begin
            fail_count <= 0;
        end
        else
        begin
            errs = 0;
            if (s_axis_tvalid && s_axis_tready)
                expected_mats.push_back(rotation_of(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_mats.size() == 0)
                begin
                    $display("%0t: unexpected transfer, expected none actual %h", $time,
                             m_axis_tdata);
                    errs++;
                end
                else
                begin
                    want = expected_mats.pop_front();
                    for (int i = 0; i < 9; i++)
                        if (m_axis_tdata[32*i +: 32] !== want.entries[32*i +: 32])
                        begin
                            $display("%0t: entry %0d expected %h actual %h", $time, i,
                                     want.entries[32*i +: 32], m_axis_tdata[32*i +: 32]);
                            errs++;
                        end
                    if (m_axis_tuser !== want.degen)
                    begin
                        $display("%0t: degenerate expected %b actual %b", $time,
                                 want.degen, m_axis_tuser);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
        end
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// top of the rotation matrix unit testbench: clock, reset, stimulus and verdict
// depends on aarm_pkg, tb_rotation_checker and the unit under test

module tb_top
    import aarm_pkg::*;
();

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [287:0] m_axis_tdata;
    logic         m_axis_tuser;
    int           fail_count;
    int           pending;
    int           send_idle;
    int           recv_stall;

    axis_angle_rotation_matrix_unit u_dut (.*);

    tb_rotation_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever
            #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'd0;
            3: return 32'($signed($urandom_range(8)) - 4);
            4: return $urandom >> $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_rotation(logic [31:0] angle, logic [31:0] ax, logic [31:0] ay,
                                 logic [31:0] az);
        while ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {az, ay, ax, angle};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] half_pi;
        int          waited;
        half_pi = 32'd421657428;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        send_idle = 0;
        recv_stall = 0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero axis, extremes, quadrant boundaries
        send_rotation(32'h1000_0000, 0, 0, 0);
        send_rotation(32'h8000_0000, 0, 0, 0);
        send_rotation(32'h8000_0000, 32'h0001_0000, 0, 0);
        send_rotation(32'h7fff_ffff, 0, 32'h0001_0000, 0);
        send_rotation(0, 0, 0, 32'h0001_0000);
        send_rotation(half_pi, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_rotation(half_pi * 2, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_rotation(half_pi * 3, 1, 32'hffff_ffff, 1);
        send_rotation(-half_pi, 32'h8000_0000, 32'h7fff_ffff, 0);
        send_rotation(half_pi / 2, 1, 0, 0);
        send_rotation(-(half_pi / 2), 0, 32'hffff_ffff, 0);
        send_rotation(half_pi * 4, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send_rotation(32'hffff_ffff, 32'h1234_5678, 32'hedcb_a988, 32'h0000_0100);
        send_rotation(1, 32'h7fff_ffff, 0, 32'h8000_0000);

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle = (phase == 1 || phase == 3) ? (phase == 1 ? 67 : 26) : 0;
            recv_stall = (phase == 2 || phase == 3) ? (phase == 2 ? 67 : 26) : 0;
            for (int n = 0; n < 360; n++)
                send_rotation(pick_word(), pick_word(), pick_word(), pick_word());
            s_axis_tvalid <= 1'b0;
            if (phase == 1)
            begin
                while (pending != 0)
                    @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b0;
        recv_stall = 0;

        waited = 0;
        while (pending != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (TOTAL_LAT + 20)
            @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
